@@ design/assert_macros.svh @@
// Assertion macros used by the transcoder top level.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low reset disable.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `ASSERT_CLK(lbl, clk, rstn, !(expr), msg)

`endif

@@ design/u8u16_pkg.sv @@
// Package for the UTF-8 to UTF-16 transcoder: payload types, unit bundle,
// shared constants. No dependencies.
package u8u16_pkg;

  localparam int MaxUnits      = 4;   // most code units one byte can cause
  localparam int UnitIdxW      = $clog2(MaxUnits);
  localparam int UnitCntW      = $clog2(MaxUnits + 1);
  localparam int QueueDepthDef = 4;

  localparam logic [15:0] UnitRepl = 16'hFFFD;
  localparam logic [15:0] UnitTerm = 16'h0000;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_terminator;
    logic        last_of_run;
  } out_item_t;

  // All units caused by one byte; the last one is the terminator if has_term.
  typedef struct packed {
    logic [UnitIdxW-1:0]           last_idx;
    logic                          has_term;
    logic [MaxUnits-1:0][15:0]     units;
  } bundle_t;

endpackage

@@ design/utf8_to_utf16_transcoder.sv @@
// Top level of the UTF-8 to UTF-16 transcoder: front decoder, bundle queue,
// back serializer. Depends on u8u16_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one UTF-8 byte
//   per transfer, with end_of_string set on the last byte of a string.
//   Output channel (out_valid_o / out_stall_i / out_item_o) gives one UTF-16
//   code unit per transfer; last_of_run marks the final unit of a byte, and
//   a byte flagged as string end closes with a zero unit, is_terminator set.
//   The bundle is queued at the input transfer; its first unit goes to the
//   output register once it heads the queue and that register is free.
//   Throughput: the front takes one byte per cycle unless the queue is full;
//   the output register moves one unit per cycle unless the receiver stalls,
//   so a byte causing n units (n is 0 to 4) holds the back part until all n
//   are out, and bytes causing at most one unit run at one per cycle; bursts
//   are absorbed by a queue of QueueDepth bundles.
//   Reset: decoder idle (nothing pending), queue empty, no output valid.
//   Receiver stall: the output unit holds, the queue fills, and once it is
//   full in_stall_o rises until the back part pops a bundle.
`include "assert_macros.svh"

module utf8_to_utf16_transcoder import u8u16_pkg::*; #(
  parameter int QueueDepth = QueueDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // front -> queue
  logic    q_push;
  bundle_t q_push_data;
  logic    q_full;
  // queue -> back
  logic    q_pop;
  bundle_t q_head;
  logic    q_empty;
  // decoder has a multi-byte sequence open
  logic    pending;
  // check helpers
  logic    out_term;
  logic    in_eos_fire;

  u8u16_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (q_push),
    .bundle_o   (q_push_data),
    .q_full_i   (q_full),
    .pending_o  (pending)
  );

  u8u16_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  u8u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  assign out_term    = out_valid_o && out_item_o.is_terminator;
  assign in_eos_fire = in_valid_i && !in_stall_o && in_item_i.end_of_string;

  // Checks
  `ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, q_push && q_full, "push into full queue")
  `ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, q_pop && q_empty, "pop from empty queue")
  `ASSERT_CLK(a_term_is_last, clk_i, rst_ni, out_term |-> out_item_o.last_of_run, "term not last")
  `ASSERT_CLK(a_idle_after_end, clk_i, rst_ni, in_eos_fire |=> !pending, "open after end")

endmodule

@@ design/u8u16_front.sv @@
// Front part: accepts UTF-8 bytes, runs the decoder state and builds the
// bundle of code units for each byte. Depends on u8u16_pkg.
module u8u16_front import u8u16_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     push_o,
  output bundle_t  bundle_o,
  input  logic     q_full_i,
  output logic     pending_o
);

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] Len2    = 3'd2;
  localparam logic [2:0] Len3    = 3'd3;
  localparam logic [2:0] Len4    = 3'd4;

  logic [20:0] pcp_q, pcp_d;
  logic [2:0]  exp_q, exp_d;
  logic [1:0]  seen_q, seen_d;

  logic [7:0]  b;
  logic        eos;
  logic        accept;
  logic        is_cont;
  logic [2:0]  seen_inc;
  logic [20:0] shifted;
  logic [20:0] v;
  logic [15:0] hi_unit, lo_unit;
  logic        is_ascii;
  logic [2:0]  lead_len;
  logic [20:0] lead_bits;
  logic        fresh;
  logic [1:0]  errs;
  logic [UnitCntW-1:0]       n;
  logic [MaxUnits-1:0][15:0] units;

  assign b        = in_item_i.in_byte;
  assign eos      = in_item_i.end_of_string;
  assign accept   = in_valid_i && !q_full_i;
  assign is_cont  = (b[7:6] == 2'b10);
  assign seen_inc = {1'b0, seen_q} + 3'd1;
  assign shifted  = {pcp_q[14:0], b[5:0]};
  assign v        = shifted - 21'h010000;
  assign hi_unit  = 16'hD800 + {5'b0, v[20:10]};
  assign lo_unit  = 16'hDC00 + {6'b0, v[9:0]};
  assign is_ascii = !b[7];

  always_comb begin
    lead_len  = LenNone;
    lead_bits = '0;
    if (b inside {[8'hC0:8'hDF]}) begin
      lead_len  = Len2;
      lead_bits = {16'b0, b[4:0]};
    end else if (b inside {[8'hE0:8'hEF]}) begin
      lead_len  = Len3;
      lead_bits = {17'b0, b[3:0]};
    end else if (b inside {[8'hF0:8'hF7]}) begin
      lead_len  = Len4;
      lead_bits = {18'b0, b[2:0]};
    end
  end

  always_comb begin
    units  = '0;
    n      = '0;
    pcp_d  = pcp_q;
    exp_d  = exp_q;
    seen_d = seen_q;
    fresh  = 1'b0;
    errs   = 2'd1;
    if (exp_q != LenNone) begin
      if (is_cont) begin
        pcp_d = shifted;
        if (seen_inc >= exp_q) begin
          if (|shifted[20:16]) begin
            units[n[UnitIdxW-1:0]] = hi_unit;
            n = n + UnitCntW'(1);
            units[n[UnitIdxW-1:0]] = lo_unit;
            n = n + UnitCntW'(1);
          end else begin
            units[n[UnitIdxW-1:0]] = shifted[15:0];
            n = n + UnitCntW'(1);
          end
          pcp_d  = '0;
          exp_d  = LenNone;
          seen_d = '0;
        end else if (eos) begin
          // cut short: one replacement per byte received
          for (int k = 0; k < 3; k++) begin
            if (3'(k) < seen_inc) begin
              units[n[UnitIdxW-1:0]] = UnitRepl;
              n = n + UnitCntW'(1);
            end
          end
          pcp_d  = '0;
          exp_d  = LenNone;
          seen_d = '0;
        end else begin
          seen_d = seen_inc[1:0];
        end
      end else begin
        // broken sequence; breaking byte is decoded again below
        if (eos && (seen_inc < exp_q)) begin
          errs = seen_q;
        end
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < errs) begin
            units[n[UnitIdxW-1:0]] = UnitRepl;
            n = n + UnitCntW'(1);
          end
        end
        pcp_d  = '0;
        exp_d  = LenNone;
        seen_d = '0;
        fresh  = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (is_ascii) begin
        units[n[UnitIdxW-1:0]] = {8'h00, b};
        n = n + UnitCntW'(1);
      end else if ((lead_len == LenNone) || eos) begin
        units[n[UnitIdxW-1:0]] = UnitRepl;
        n = n + UnitCntW'(1);
      end else begin
        pcp_d  = lead_bits;
        exp_d  = lead_len;
        seen_d = 2'd1;
      end
    end

    if (eos) begin
      units[n[UnitIdxW-1:0]] = UnitTerm;
      n = n + UnitCntW'(1);
      pcp_d  = '0;
      exp_d  = LenNone;
      seen_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcp_q  <= '0;
      exp_q  <= LenNone;
      seen_q <= '0;
    end else if (accept) begin
      pcp_q  <= pcp_d;
      exp_q  <= exp_d;
      seen_q <= seen_d;
    end
  end

  assign in_stall_o        = q_full_i;
  assign push_o            = accept && (n != '0);
  assign bundle_o.last_idx = UnitIdxW'(n - UnitCntW'(1));
  assign bundle_o.has_term = eos;
  assign bundle_o.units    = units;
  assign pending_o         = (exp_q != LenNone);

endmodule

@@ design/u8u16_fifo.sv @@
// Short bundle queue between front and back parts.
// Depends on u8u16_pkg (bundle_t, default depth).
module u8u16_fifo import u8u16_pkg::*; #(
  parameter int Depth = QueueDepthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t push_data_i,
  output logic    full_o,
  input  logic    pop_i,
  output bundle_t head_o,
  output logic    empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  bundle_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);

endmodule

@@ design/u8u16_back.sv @@
// Back part: walks the head bundle one code unit per cycle, while the receiver
// does not stall, into the output register. Depends on u8u16_pkg.
module u8u16_back import u8u16_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bundle_t   head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic [UnitIdxW-1:0] idx_q;
  logic                out_valid_q;
  out_item_t           out_q;
  logic                load;
  logic                is_last;

  assign load    = !empty_i && (!out_valid_q || !out_stall_i);
  assign is_last = (idx_q == head_i.last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      idx_q       <= is_last ? '0 : idx_q + UnitIdxW'(1);
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.code_unit     <= head_i.units[idx_q];
      out_q.is_terminator <= head_i.has_term && is_last;
      out_q.last_of_run   <= is_last;
    end
  end

  assign pop_o       = load && is_last;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
